// ----- src/lhst_pkg.sv -----
// Package for the heard-station table: command codes, entry record, search control.
// No dependencies.
package lhst_pkg;

  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_RECENT = 2'd2;
  localparam logic [1:0] CMD_IFACE  = 2'd3;

  localparam logic [7:0]  TYPE_SPACE     = 8'h20;
  localparam logic [15:0] WINDOW_DEFAULT = 16'd3600;

  localparam logic [1:0] REG_DTI    = 2'd0;
  localparam logic [1:0] REG_MAX    = 2'd1;
  localparam logic [1:0] REG_WINDOW = 2'd2;

  typedef struct packed {
    logic [55:0] address;
    logic [3:0]  iface;
    logic [7:0]  code;
    logic [31:0] count;
    logic [31:0] stamp;
  } entry_t;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic        shift;  // cells at or below the end position take the entry above
    logic        load;   // the front cell takes the new entry
    logic        pull;   // cells at or past the hole take the entry below
  } cell_ctl_t;

endpackage

// ----- src/lru_heard_station_table.sv -----
// Top level of the heard-station table: chain of entry cells, search sequencer, ports.
// Depends on lhst_pkg and lhst_cell.
//
//  channel | direction | tdata fields (low to high)                       | tuser
//  s_axis  | in        | command, callsign, iface_id, type_code, now (104) | none
//  m_axis  | out       | hit, recent, heard_iface, packet_count, stored (48)| none
//  cfg     | in        | cfg_we, cfg_index, cfg_data                      | -
//
// An item is captured in ST_IDLE, searched in ST_WALK one entry at a time from the front
// until the search is done, an empty entry is met or the last position is reached, then
// shifted for the move or delete in ST_APPLY and presented as a result in ST_OUT.
// Reset empties the table at once. A stalled result holds the block; no new item is
// taken until the result transfers.
module lru_heard_station_table #(
  parameter int ENTRIES = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,   // command, callsign, iface_id, type_code, now_seconds
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,   // hit, recent, heard_iface, packet_count, stored_entries
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int PW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]  state;
  logic        dti_mode;
  logic [5:0]  max_entries;
  logic [15:0] recent_window;

  logic [1:0]  cmd;
  logic [55:0] addr;
  logic [3:0]  ifc;
  logic [7:0]  typ;
  logic [31:0] now;

  logic [CW-1:0] valid_count;
  logic [PW-1:0] pos;
  logic [CW-1:0] hole;     // position of the matched entry
  logic          found;
  logic          done;
  logic          hit, recent;
  logic [3:0]  hiface;
  logic [31:0] pcount;
  lhst_pkg::entry_t hit_entry;

  lhst_pkg::entry_t  ent [ENTRIES];
  logic [ENTRIES-1:0] vld;
  lhst_pkg::cell_ctl_t ctl;
  lhst_pkg::entry_t  new_entry;

  logic [CW-1:0] limit;
  logic [CW-1:0] miss_hole;
  logic [CW-1:0] shift_end;

  // Cell chain. On a shift the element at the end position is discarded and the rest
  // move back; on a pull the element at the hole is discarded and the rest move forward.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lhst_pkg::entry_t up_e;
    logic up_v;
    lhst_pkg::entry_t down_e;
    logic down_v;
    if (g == 0) begin : g_front
      assign up_e = new_entry;
      assign up_v = 1'b1;
    end else begin : g_rest
      assign up_e = ent[g-1];
      assign up_v = vld[g-1];
    end
    if (g == ENTRIES - 1) begin : g_back
      assign down_e = new_entry;
      assign down_v = 1'b0;
    end else begin : g_inner
      assign down_e = ent[g+1];
      assign down_v = vld[g+1];
    end
    lhst_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl),
      .sel(CW'(g) <= shift_end),
      .pull_sel(CW'(g) >= hole),
      .up_entry(up_e), .up_valid(up_v),
      .down_entry(down_e), .down_valid(down_v),
      .new_entry(new_entry), .is_front(g == 0),
      .entry(ent[g]), .valid(vld[g])
    );
  end

  always_comb begin
    if (max_entries == 6'd0 || 32'(max_entries) > ENTRIES) limit = CW'(ENTRIES);
    else limit = CW'(max_entries);
  end

  assign miss_hole = (valid_count >= limit && valid_count != '0) ?
                     valid_count - CW'(1) : valid_count;
  assign shift_end = found ? hole : miss_hole;

  lhst_pkg::entry_t cur;
  logic cur_live, addr_eq, upd_eq, stale;
  logic [31:0] age;
  assign cur      = ent[pos];
  assign cur_live = vld[pos];
  assign addr_eq  = cur.address == addr;
  assign upd_eq   = addr_eq && cur.iface == ifc && (!dti_mode || cur.code == typ);
  assign age      = now - cur.stamp;
  assign stale    = !(age[31] || age <= {16'd0, recent_window});

  always_comb begin
    new_entry.address = addr;
    new_entry.iface   = ifc;
    new_entry.code    = dti_mode ? typ : lhst_pkg::TYPE_SPACE;
    new_entry.stamp   = now;
    new_entry.count   = (found ? hit_entry.count : 32'd0) + 32'd1;
  end

  always_comb begin
    ctl.shift = 1'b0;
    ctl.load  = 1'b0;
    ctl.pull  = 1'b0;
    if (state == ST_APPLY && cmd == lhst_pkg::CMD_UPDATE) begin
      ctl.shift = 1'b1;
      ctl.load  = 1'b1;
    end
    if (state == ST_APPLY && cmd == lhst_pkg::CMD_REMOVE && found) begin
      ctl.pull = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dti_mode      <= 1'b0;
      max_entries   <= 6'd0;
      recent_window <= lhst_pkg::WINDOW_DEFAULT;
    end else if (cfg_we) begin
      case (cfg_index)
        lhst_pkg::REG_DTI:    dti_mode      <= cfg_data[0];
        lhst_pkg::REG_MAX:    max_entries   <= cfg_data[5:0];
        lhst_pkg::REG_WINDOW: recent_window <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      valid_count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (!cur_live || done || 32'(pos) == ENTRIES - 1) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (cmd == lhst_pkg::CMD_UPDATE && !found && valid_count < limit) begin
            valid_count <= valid_count + CW'(1);
          end
          if (cmd == lhst_pkg::CMD_REMOVE && found) begin
            valid_count <= valid_count - CW'(1);
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cmd <= s_axis_tdata[1:0];
        addr <= s_axis_tdata[57:2];
        ifc <= s_axis_tdata[61:58];
        typ <= s_axis_tdata[69:62];
        now <= s_axis_tdata[101:70];
        pos <= '0;
        found <= 1'b0;
        done <= 1'b0;
        hit <= 1'b0;
        recent <= 1'b0;
        hiface <= 4'd0;
        pcount <= 32'd0;
        hole <= '0;
      end
      ST_WALK: begin
        if (cur_live && !done) begin
          case (cmd)
            lhst_pkg::CMD_UPDATE: begin
              if (upd_eq) begin
                found <= 1'b1; done <= 1'b1; hole <= CW'(pos); hit_entry <= cur;
              end
            end
            lhst_pkg::CMD_REMOVE, lhst_pkg::CMD_IFACE: begin
              if (addr_eq) begin
                found <= 1'b1; done <= 1'b1; hit <= 1'b1; hiface <= cur.iface;
                hole <= CW'(pos);
              end
            end
            default: begin
              if (addr_eq) begin
                if (!hit) begin
                  hit <= 1'b1; hiface <= cur.iface;
                end
                if (!stale) begin
                  recent <= 1'b1; done <= 1'b1;
                end else if (!dti_mode) begin
                  done <= 1'b1;
                end
              end
            end
          endcase
          if (32'(pos) < ENTRIES - 1) pos <= pos + PW'(1);
        end
      end
      ST_APPLY: begin
        if (cmd == lhst_pkg::CMD_UPDATE) begin
          hit <= found;
          hiface <= ifc;
          pcount <= new_entry.count;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {4'b0000, 6'(valid_count), pcount, hiface, recent, hit};

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Result changed while it waits.");
  a_depth: assert property (@(posedge clk) disable iff (rst)
    valid_count <= CW'(ENTRIES))
    else $error("Entry count is above the depth.");
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("Input is ready while a result waits.");
  a_front_live: assert property (@(posedge clk) disable iff (rst)
    vld[0] == (valid_count != '0))
    else $error("Front valid bit disagrees with the entry count.");

endmodule

// ----- src/lhst_cell.sv -----
// One position of the recency-ordered chain: holds one entry and its valid bit.
// Depends on lhst_pkg.
module lhst_cell (
  input  logic             clk,
  input  logic             rst,
  input  lhst_pkg::cell_ctl_t ctl,
  input  logic             sel,       // this position takes part in the shift
  input  logic             pull_sel,  // this position takes part in the pull
  input  lhst_pkg::entry_t up_entry,
  input  logic             up_valid,
  input  lhst_pkg::entry_t down_entry,
  input  logic             down_valid,
  input  lhst_pkg::entry_t new_entry,
  input  logic             is_front,
  output lhst_pkg::entry_t entry,
  output logic             valid
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.load && is_front) begin
      valid <= 1'b1;
    end else if (ctl.shift && sel) begin
      valid <= up_valid;
    end else if (ctl.pull && pull_sel) begin
      valid <= down_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && is_front) begin
      entry <= new_entry;
    end else if (ctl.shift && sel) begin
      entry <= up_entry;
    end else if (ctl.pull && pull_sel) begin
      entry <= down_entry;
    end
  end

endmodule
